### rtl/fmt_pkg.sv
// fmt_pkg: shared constants, codes and types of the fold mask threshold block
// used by fold_mask_threshold, fmt_checker and the testbench
`default_nettype none

package fmt_pkg;

	localparam int MAX_LINE    = 256;
	localparam int MAX_LINES   = 256;
	localparam int STORE_DEPTH = MAX_LINE * MAX_LINES;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	localparam int PIX_W    = 8;
	localparam int DIM_W    = 9;
	localparam int COORD_W  = 8;
	localparam int CNT_W    = 17;
	localparam int SUM_W    = 25;
	localparam int SQ_W     = 33;
	localparam int SPREAD_W = 51;
	localparam int QLO_W    = 17;
	localparam int QHI_W    = SQ_W - QLO_W;
	localparam int CFG_IDX_W = 2;
	localparam int IN_DATA_W = 24;
	localparam int OUT_DATA_W = 8;
	localparam int STATUS_W  = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STAT_FLOOR  = 2'd2;

	localparam logic [DIM_W-1:0] LINE_LENGTH_RST = 9'd256;
	localparam logic [DIM_W-1:0] LINE_COUNT_RST  = 9'd256;
	localparam logic [PIX_W-1:0] STAT_FLOOR_RST  = 8'd40;

	// commands
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// result status
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIN1,
		S_FIN2,
		S_FIN3,
		S_FIN4,
		S_READ,
		S_CALC1,
		S_CALC2,
		S_CALC3,
		S_CALC4,
		S_RESULT
	} state_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] hi);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/fmt_ram.sv
// fmt_ram: generic single-port synchronous ram with a registered read
// no dependencies
`default_nettype none

module fmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

### rtl/fold_mask_threshold.sv
// fold_mask_threshold: loads a frame into a store, keeps brightness statistics
// and answers fold-bit queries; depends on fmt_pkg and fmt_ram
// items are taken only in S_IDLE; the last load of a frame runs S_FIN1 to S_FIN4,
// the frame statistics (n*Q in two halves, S*S, (S-n)^2), before the next item
// a query on a loaded frame makes five store reads through the single ram port,
// then four multiply/compare steps, before its result is registered
// a query on an unready frame or outside it goes straight to its result
// reset clears the counts, statistics and control; the frame store is not cleared
`default_nettype none

module fold_mask_threshold
	import fmt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,  // pixel, query_line, query_pos
	input  wire logic                  s_tuser,  // command
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic      [OUT_DATA_W-1:0] m_tdata,  // fold, zero fill
	output logic      [STATUS_W-1:0]   m_tuser,  // status
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [DIM_W-1:0]      cfg_data
);

	// read slots of a query
	localparam logic [2:0] RD_CENTER = 3'd0;
	localparam logic [2:0] RD_LEFT   = 3'd1;
	localparam logic [2:0] RD_RIGHT  = 3'd2;
	localparam logic [2:0] RD_UP     = 3'd3;
	localparam logic [2:0] RD_DOWN   = 3'd4;
	localparam logic [2:0] RD_LAST   = 3'd5;

	state_t state_q, state_nxt;

	logic [DIM_W-1:0]    line_length_q, line_count_q;
	logic [PIX_W-1:0]    stat_floor_q;
	logic [CNT_W-1:0]    load_count_q, bright_count_q;
	logic [SUM_W-1:0]    bright_sum_q;
	logic [SQ_W-1:0]     bright_sum_sq_q;
	logic [SPREAD_W-1:0] spread_q;
	logic                use_fallback_q, frame_ready_q;

	logic [CNT_W+QLO_W-1:0] nql_q;
	logic [CNT_W+QHI_W-1:0] nqh_q;
	logic [2*SUM_W-1:0]     ss_q, mm_q;
	logic [SUM_W-1:0]       mdiff_q;
	logic                   mneg_q;

	logic [ADDR_W-1:0]  base_q;
	logic               has_l_q, has_r_q, has_u_q, has_d_q;
	logic [2:0]         rd_cnt_q;
	logic [PIX_W-1:0]   pix_q;
	logic               zero_q;
	logic [SUM_W-1:0]   np_s1, d_s2;
	logic               gt_s2, fb_s2;
	logic [2*SUM_W-1:0] dd_s3;
	logic               res_fold_q;
	logic [STATUS_W-1:0] res_status_q;
	logic               out_valid_q, out_fold_q;
	logic [STATUS_W-1:0] out_status_q;

	logic [DIM_W-1:0]   eff_w, eff_h;
	logic [2*DIM_W-1:0] total;
	logic               in_acc, is_load, is_query, cfg_hit, out_free;
	logic [PIX_W-1:0]   in_pixel;
	logic [COORD_W-1:0] in_y, in_x;
	logic [CNT_W-1:0]   ld_cnt, ld_cnt_nxt;
	logic               frame_done, out_of_range;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_addr, rd_addr;
	logic [PIX_W-1:0]   ram_rdata;
	logic [ADDR_W-1:0]  q_index;
	logic [2*SUM_W-1:0] nq_full, diff_full;

	assign eff_w = clamp_dim(line_length_q, DIM_W'(MAX_LINE));
	assign eff_h = clamp_dim(line_count_q, DIM_W'(MAX_LINES));
	assign total = eff_w * eff_h;

	assign in_pixel = s_tdata[PIX_W-1:0];
	assign in_y     = s_tdata[PIX_W+COORD_W-1:PIX_W];
	assign in_x     = s_tdata[PIX_W+2*COORD_W-1:PIX_W+COORD_W];

	assign in_acc   = s_tvalid && s_tready;
	assign is_load  = in_acc && (s_tuser == CMD_LOAD);
	assign is_query = in_acc && (s_tuser == CMD_QUERY);
	assign cfg_hit  = cfg_we && (cfg_index == REG_LINE_LENGTH
		|| cfg_index == REG_LINE_COUNT || cfg_index == REG_STAT_FLOOR);
	assign out_free = !out_valid_q || m_tready;

	// a load after a complete frame starts over at position zero
	assign ld_cnt       = frame_ready_q ? '0 : load_count_q;
	assign ld_cnt_nxt   = ld_cnt + CNT_W'(1);
	assign frame_done   = ({1'b0, ld_cnt_nxt} == total);
	assign out_of_range = ({1'b0, in_y} >= eff_h) || ({1'b0, in_x} >= eff_w);
	assign q_index      = ADDR_W'(in_y) * ADDR_W'(eff_w) + ADDR_W'(in_x);

	always_comb begin
		case (rd_cnt_q)
			RD_LEFT:  rd_addr = base_q - ADDR_W'(1);
			RD_RIGHT: rd_addr = base_q + ADDR_W'(1);
			RD_UP:    rd_addr = base_q - ADDR_W'(eff_w);
			RD_DOWN:  rd_addr = base_q + ADDR_W'(eff_w);
			default:  rd_addr = base_q;
		endcase
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (is_load && frame_done) begin
					state_nxt = S_FIN1;
				end else if (is_query) begin
					if (!frame_ready_q || out_of_range) begin
						state_nxt = S_RESULT;
					end else begin
						state_nxt = S_READ;
					end
				end
			end
			S_FIN1:  state_nxt = S_FIN2;
			S_FIN2:  state_nxt = S_FIN3;
			S_FIN3:  state_nxt = S_FIN4;
			S_FIN4:  state_nxt = S_IDLE;
			S_READ: begin
				if (rd_cnt_q == RD_LAST) begin
					state_nxt = S_CALC1;
				end
			end
			S_CALC1: state_nxt = S_CALC2;
			S_CALC2: state_nxt = S_CALC3;
			S_CALC3: state_nxt = S_CALC4;
			S_CALC4: state_nxt = S_RESULT;
			S_RESULT: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_tready = 1'b0;
		ram_we   = 1'b0;
		ram_addr = rd_addr;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				ram_we   = is_load;
				ram_addr = ld_cnt[ADDR_W-1:0];
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	fmt_ram #(
		.WIDTH(PIX_W),
		.DEPTH(STORE_DEPTH)
	) u_frame_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(in_pixel),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// configuration and frame statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q   <= LINE_LENGTH_RST;
			line_count_q    <= LINE_COUNT_RST;
			stat_floor_q    <= STAT_FLOOR_RST;
			load_count_q    <= '0;
			bright_count_q  <= '0;
			bright_sum_q    <= '0;
			bright_sum_sq_q <= '0;
			spread_q        <= '0;
			use_fallback_q  <= 1'b0;
			frame_ready_q   <= 1'b0;
		end else if (cfg_hit) begin
			case (cfg_index)
				REG_LINE_LENGTH: line_length_q <= cfg_data;
				REG_LINE_COUNT:  line_count_q  <= cfg_data;
				REG_STAT_FLOOR:  stat_floor_q  <= cfg_data[PIX_W-1:0];
				default:         line_length_q <= line_length_q;
			endcase
			load_count_q    <= '0;
			bright_count_q  <= '0;
			bright_sum_q    <= '0;
			bright_sum_sq_q <= '0;
			spread_q        <= '0;
			use_fallback_q  <= 1'b0;
			frame_ready_q   <= 1'b0;
		end else begin
			if (is_load) begin
				load_count_q  <= ld_cnt_nxt;
				frame_ready_q <= 1'b0;
				if (frame_ready_q) begin
					spread_q       <= '0;
					use_fallback_q <= 1'b0;
				end
				if (in_pixel > stat_floor_q) begin
					bright_count_q  <= (frame_ready_q ? '0 : bright_count_q) + CNT_W'(1);
					bright_sum_q    <= (frame_ready_q ? '0 : bright_sum_q) + SUM_W'(in_pixel);
					bright_sum_sq_q <= (frame_ready_q ? '0 : bright_sum_sq_q)
						+ SQ_W'(in_pixel) * SQ_W'(in_pixel);
				end else if (frame_ready_q) begin
					bright_count_q  <= '0;
					bright_sum_q    <= '0;
					bright_sum_sq_q <= '0;
				end
			end
			if (state_q == S_FIN3) begin
				spread_q <= SPREAD_W'({diff_full, 2'b00});
			end
			if (state_q == S_FIN4) begin
				use_fallback_q <= mneg_q || ({1'b0, mm_q} < spread_q);
				frame_ready_q  <= 1'b1;
			end
		end
	end

	// end-of-frame arithmetic: 4*(n*Q - S*S) and the reduced-rule test
	assign nq_full   = {nqh_q[2*SUM_W-QLO_W-1:0], {QLO_W{1'b0}}} + (2*SUM_W)'(nql_q);
	assign diff_full = nq_full - ss_q;

	always_ff @(posedge clk) begin
		if (state_q == S_FIN1) begin
			nql_q   <= bright_count_q * bright_sum_sq_q[QLO_W-1:0];
			ss_q    <= bright_sum_q * bright_sum_q;
			mneg_q  <= (bright_sum_q < SUM_W'(bright_count_q));
			mdiff_q <= bright_sum_q - SUM_W'(bright_count_q);
		end
		if (state_q == S_FIN2) begin
			nqh_q <= bright_count_q * bright_sum_sq_q[SQ_W-1:QLO_W];
			mm_q  <= mdiff_q * mdiff_q;
		end
	end

	// query read sequence and fold decision
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q <= RD_CENTER;
		end else if (state_q == S_READ) begin
			rd_cnt_q <= rd_cnt_q + 3'd1;
		end else begin
			rd_cnt_q <= RD_CENTER;
		end
	end

	always_ff @(posedge clk) begin
		if (is_query) begin
			base_q  <= q_index;
			has_l_q <= (in_x != '0);
			has_r_q <= ({1'b0, in_x} + DIM_W'(1) < eff_w);
			has_u_q <= (in_y != '0);
			has_d_q <= ({1'b0, in_y} + DIM_W'(1) < eff_h);
			zero_q  <= 1'b0;
			res_fold_q <= 1'b0;
			if (!frame_ready_q) begin
				res_status_q <= ST_NOT_READY;
			end else if (out_of_range) begin
				res_status_q <= ST_RANGE;
			end else begin
				res_status_q <= ST_OK;
			end
		end
		// read data lags the address by one slot
		if (state_q == S_READ) begin
			case (rd_cnt_q)
				RD_LEFT:  pix_q <= ram_rdata;
				RD_RIGHT: if (has_l_q && ram_rdata == '0) zero_q <= 1'b1;
				RD_UP:    if (has_r_q && ram_rdata == '0) zero_q <= 1'b1;
				RD_DOWN:  if (has_u_q && ram_rdata == '0) zero_q <= 1'b1;
				RD_LAST:  if (has_d_q && ram_rdata == '0) zero_q <= 1'b1;
				default:  zero_q <= zero_q;
			endcase
		end
		if (state_q == S_CALC1) begin
			np_s1 <= bright_count_q * (zero_q ? '0 : pix_q);
		end
		if (state_q == S_CALC2) begin
			gt_s2 <= (bright_sum_q > np_s1);
			d_s2  <= bright_sum_q - np_s1;
			// 20*n*pix < S
			fb_s2 <= ({np_s1, 4'b0000} + {2'b00, np_s1, 2'b00}) < (SUM_W+4)'(bright_sum_q);
		end
		if (state_q == S_CALC3) begin
			dd_s3 <= d_s2 * d_s2;
		end
		if (state_q == S_CALC4) begin
			res_fold_q <= (bright_count_q != '0) && (use_fallback_q ? fb_s2
				: (gt_s2 && ({1'b0, dd_s3} > spread_q)));
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_RESULT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESULT && out_free) begin
			out_fold_q   <= res_fold_q;
			out_status_q <= res_status_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W-1){1'b0}}, out_fold_q};
	assign m_tuser  = out_status_q;

endmodule

`default_nettype wire

### rtl/fmt_checker.sv
// fmt_checker: port-level assertions for fold_mask_threshold, bound to the top
// depends on fmt_pkg
`default_nettype none

module fmt_checker
	import fmt_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_tvalid,
	input wire logic                  s_tready,
	input wire logic                  s_tuser,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [OUT_DATA_W-1:0] m_tdata,
	input wire logic [STATUS_W-1:0]   m_tuser,
	input wire logic                  cfg_we,
	input wire logic [CFG_IDX_W-1:0]  cfg_index
);

	logic not_ready_q, expect_q;
	logic cfg_hit, load_acc, query_acc, out_acc;

	assign cfg_hit   = cfg_we && (cfg_index == REG_LINE_LENGTH
		|| cfg_index == REG_LINE_COUNT || cfg_index == REG_STAT_FLOOR);
	assign load_acc  = s_tvalid && s_tready && (s_tuser == CMD_LOAD);
	assign query_acc = s_tvalid && s_tready && (s_tuser == CMD_QUERY);
	assign out_acc   = m_tvalid && m_tready;

	// no load since reset or since a register write: frame cannot be complete
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			not_ready_q <= 1'b1;
		end else if (cfg_hit) begin
			not_ready_q <= 1'b1;
		end else if (load_acc) begin
			not_ready_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_q <= 1'b0;
		end else if (query_acc) begin
			expect_q <= not_ready_q;
		end else if (out_acc) begin
			expect_q <= 1'b0;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result item changed while stalled");

	a_fold_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_OK) |-> (m_tdata[0] == 1'b0))
		else $error("fold set on a failed query");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		query_acc |=> !s_tready)
		else $error("item accepted right after a query");

	a_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && expect_q |-> (m_tuser == ST_NOT_READY))
		else $error("query on an unloaded frame did not report not ready");

endmodule

bind fold_mask_threshold fmt_checker u_fmt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.cfg_we   (cfg_we),
	.cfg_index(cfg_index)
);

`default_nettype wire

### tb/testbench.sv
// testbench: self-checking bench for fold_mask_threshold, frame loads and fold-bit queries
// uses fmt_pkg for port widths and codes, predicts results with its own frame model or takes them from typed plan rows
`timescale 1ns / 1ps

module testbench;
	import fmt_pkg::*;

	typedef struct packed {
		logic                fold;
		logic [STATUS_W-1:0] status;
	} fold_result_t;

	typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_QUERY} row_kind_t;

	typedef struct {
		row_kind_t           kind;
		int                  a;      // register index or query line
		int                  b;      // register value, pixel or query position
		bit                  typed;
		logic                fold;
		logic [STATUS_W-1:0] st;
	} plan_row_t;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]   m_tuser;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [DIM_W-1:0]      cfg_data;

	fold_mask_threshold i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// frame model
	logic [PIX_W-1:0]  frame_mem [0:STORE_DEPTH-1];
	logic [DIM_W-1:0]  len_reg;
	logic [DIM_W-1:0]  cnt_reg;
	logic [PIX_W-1:0]  floor_reg;
	int unsigned       loaded;
	longint unsigned   n_bright;
	longint unsigned   sum_bright;
	longint unsigned   sumsq_bright;
	longint unsigned   spread4;
	bit                fallback;
	bit                frame_full;

	fold_result_t fold_results_due[$];
	plan_row_t    plan[$];
	int           mismatches;
	int           items_sent;
	int           results_seen;
	int           burst_left;
	bit           steady;
	bit           long_hold_req;
	bit           long_hold_done;

	int frame_style;
	int level_a;
	int level_b;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

	task automatic note_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic void add_row(input row_kind_t kind, input int a, input int b,
			input bit typed, input logic fold, input logic [STATUS_W-1:0] st);
		plan_row_t r;
		r.kind  = kind;
		r.a     = a;
		r.b     = b;
		r.typed = typed;
		r.fold  = fold;
		r.st    = st;
		plan.insert(plan.size(), r);
	endfunction

	function automatic int span_of(input logic [DIM_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > 256)
			return 256;
		return int'(v);
	endfunction

	function automatic void clear_frame_stats();
		loaded       = 0;
		n_bright     = 0;
		sum_bright   = 0;
		sumsq_bright = 0;
		spread4      = 0;
		fallback     = 1'b0;
		frame_full   = 1'b0;
	endfunction

	function automatic void shadow_reg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [DIM_W-1:0] val);
		case (idx)
			REG_LINE_LENGTH: begin
				len_reg = val;
				clear_frame_stats();
			end
			REG_LINE_COUNT: begin
				cnt_reg = val;
				clear_frame_stats();
			end
			REG_STAT_FLOOR: begin
				floor_reg = val[PIX_W-1:0];
				clear_frame_stats();
			end
			default: ;
		endcase
	endfunction

	// returns 1 when the item causes a result
	function automatic bit advance_fold_model(input logic cmd, input logic [PIX_W-1:0] pix,
			input logic [COORD_W-1:0] line, input logic [COORD_W-1:0] pos,
			output fold_result_t r);
		int unsigned     w;
		int unsigned     h;
		int unsigned     total;
		int unsigned     i;
		longint unsigned p;
		longint unsigned np;
		longint unsigned d;
		longint unsigned m;
		longint unsigned dd;
		w = span_of(len_reg);
		h = span_of(cnt_reg);
		total = w * h;
		r = '0;
		if (cmd == CMD_LOAD) begin
			if (frame_full)
				clear_frame_stats();
			if (loaded < total) begin
				frame_mem[loaded] = pix;
				loaded++;
				p = pix;
				if (pix > floor_reg) begin
					n_bright++;
					sum_bright += p;
					sumsq_bright += p * p;
				end
			end
			if (loaded >= total) begin
				dd = n_bright * sumsq_bright - sum_bright * sum_bright;
				spread4 = (dd << 2) & ((64'd1 << SPREAD_W) - 64'd1);
				if (sum_bright < n_bright) begin
					fallback = 1'b1;
				end else begin
					m = sum_bright - n_bright;
					fallback = (m * m) < spread4;
				end
				frame_full = 1'b1;
			end
			return 1'b0;
		end
		if (!frame_full) begin
			r.status = ST_NOT_READY;
		end else if (line >= h || pos >= w) begin
			r.status = ST_RANGE;
		end else begin
			r.status = ST_OK;
			i = line * w + pos;
			p = frame_mem[i];
			// a zero 4-neighbour forces the pixel to zero
			if (pos > 0 && frame_mem[i - 1] == 0)
				p = 0;
			if (pos + 1 < w && frame_mem[i + 1] == 0)
				p = 0;
			if (line > 0 && frame_mem[i - w] == 0)
				p = 0;
			if (line + 1 < h && frame_mem[i + w] == 0)
				p = 0;
			if (n_bright == 0) begin
				r.fold = 1'b0;
			end else if (fallback) begin
				r.fold = (20 * n_bright * p) < sum_bright;
			end else begin
				np = n_bright * p;
				if (sum_bright > np) begin
					d = sum_bright - np;
					r.fold = (d * d) > spread4;
				end
			end
		end
		return 1'b1;
	endfunction

	function automatic logic [PIX_W-1:0] pick_pixel();
		int v;
		if ($urandom_range(0, 9) == 0)
			return '0;
		case (frame_style)
			0: v = $urandom_range(0, 255);
			1: v = level_a;
			2: v = ($urandom_range(0, 3) == 0) ? level_b : level_a;
			3: v = $urandom_range(0, floor_reg);
			default: v = level_a + int'($urandom_range(0, 16)) - 8;
		endcase
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v[PIX_W-1:0];
	endfunction

	// sender: bursts of items separated by random gaps, with some gap-free stretches
	task automatic offer_item(input logic cmd, input logic [PIX_W-1:0] pix,
			input logic [COORD_W-1:0] line, input logic [COORD_W-1:0] pos,
			input bit typed, input fold_result_t typed_res);
		fold_result_t res;
		int           gap;
		if (burst_left == 0) begin
			steady = ($urandom_range(0, 4) == 0);
			gap = steady ? 0 : $urandom_range(1, 6);
			burst_left = steady ? 40 : $urandom_range(1, 24);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {pos, line, pix};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (advance_fold_model(cmd, pix, line, pos, res))
			fold_results_due.insert(fold_results_due.size(), typed ? typed_res : res);
		items_sent++;
	endtask

	// wait for every result, then for the tail of any frame statistics pass
	task automatic settle_block();
		s_tvalid <= 1'b0;
		while (fold_results_due.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_reg_write(idx, val);
		@(posedge clk);
	endtask

	task automatic query_any();
		int unsigned w;
		int unsigned h;
		w = span_of(len_reg);
		h = span_of(cnt_reg);
		if ($urandom_range(0, 6) == 0)
			offer_item(CMD_QUERY, PIX_W'($urandom), COORD_W'($urandom),
				COORD_W'($urandom), 1'b0, '0);
		else
			offer_item(CMD_QUERY, PIX_W'($urandom), COORD_W'($urandom_range(0, h - 1)),
				COORD_W'($urandom_range(0, w - 1)), 1'b0, '0);
	endtask

	task automatic run_random_phases();
		int          phase;
		int          lv;
		int          cv;
		int          nframes;
		int          cut;
		int          nr_at;
		int          nq;
		int unsigned total;
		bit          broken;
		phase = 0;
		while (items_sent < 1750) begin
			settle_block();
			phase++;
			case (phase)
				2: begin lv = 256; cv = 1; end
				4: begin lv = 1; cv = 511; end
				6: begin lv = 0; cv = 0; end
				8: begin lv = 300; cv = 1; end
				default: begin
					lv = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
					cv = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
				end
			endcase
			write_reg(REG_LINE_LENGTH, lv[DIM_W-1:0]);
			write_reg(REG_LINE_COUNT, cv[DIM_W-1:0]);
			if (phase == 1 || $urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 7))
					0: write_reg(REG_STAT_FLOOR, 9'd0);
					1: write_reg(REG_STAT_FLOOR, 9'd255);
					default: write_reg(REG_STAT_FLOOR, DIM_W'($urandom_range(0, 200)));
				endcase
			end
			total = span_of(len_reg) * span_of(cnt_reg);
			nframes = (total > 64) ? 1 : $urandom_range(1, 3);
			broken = 1'b0;
			for (int f = 0; f < nframes && !broken; f++) begin
				frame_style = $urandom_range(0, 4);
				level_a = $urandom_range(0, 255);
				level_b = $urandom_range(0, 255);
				cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, total - 1) : total;
				nr_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, total - 1) : -1;
				for (int k = 0; k < cut; k++) begin
					if (k == nr_at)
						query_any();
					offer_item(CMD_LOAD, pick_pixel(), COORD_W'($urandom),
						COORD_W'($urandom), 1'b0, '0);
				end
				if (cut < total) begin
					// frame left unfinished, the next register write drops it
					query_any();
					broken = 1'b1;
				end else begin
					nq = (total > 64) ? 16 : $urandom_range(2, 10);
					if (!long_hold_done && items_sent > 700) begin
						// receiver goes quiet while queries keep coming
						long_hold_done = 1'b1;
						long_hold_req = 1'b1;
						nq = 40;
					end
					repeat (nq) query_any();
				end
			end
		end
	endtask

	// receiver: checks results and stalls on a rotating pattern
	initial begin : receiver
		fold_result_t want;
		logic [7:0]   pattern;
		int           stall_left;
		int           rx_tick;
		m_tready <= 1'b0;
		pattern = 8'hFF;
		stall_left = 0;
		rx_tick = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (fold_results_due.size() == 0) begin
					note_mismatch($sformatf("result data=%0h code=%0d with nothing due",
						m_tdata, m_tuser));
				end else begin
					want = fold_results_due.pop_front();
					if (m_tdata !== {{(OUT_DATA_W-1){1'b0}}, want.fold})
						note_mismatch($sformatf("result %0d tdata got %0h want %0h",
							results_seen, m_tdata, want.fold));
					if (m_tuser !== want.status)
						note_mismatch($sformatf("result %0d tuser got %0d want %0d",
							results_seen, m_tuser, want.status));
				end
				results_seen++;
			end
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left = 300;
			end
			rx_tick++;
			if (rx_tick % 64 == 0)
				pattern = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom | 32'h1);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= pattern[rx_tick % 8];
			end
		end
	end

	initial begin : main_flow
		plan_row_t    row;
		fold_result_t typed_res;
		mismatches = 0;
		items_sent = 0;
		results_seen = 0;
		burst_left = 0;
		steady = 1'b0;
		long_hold_req = 1'b0;
		long_hold_done = 1'b0;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= CMD_LOAD;
		cfg_we    <= 1'b0;
		cfg_index <= REG_LINE_LENGTH;
		cfg_data  <= '0;
		len_reg   = LINE_LENGTH_RST;
		cnt_reg   = LINE_COUNT_RST;
		floor_reg = STAT_FLOOR_RST;
		clear_frame_stats();

		// nothing loaded after reset
		add_row(ROW_QUERY, 0, 0, 1'b1, 1'b0, ST_NOT_READY);
		// 2x2 frame with extreme pixels, zero neighbour and flat statistics
		add_row(ROW_CFG, int'(REG_LINE_LENGTH), 2, 1'b0, 1'b0, ST_OK);
		add_row(ROW_CFG, int'(REG_LINE_COUNT), 2, 1'b0, 1'b0, ST_OK);
		add_row(ROW_CFG, int'(REG_STAT_FLOOR), 0, 1'b0, 1'b0, ST_OK);
		add_row(ROW_LOAD, 0, 0, 1'b0, 1'b0, ST_OK);
		add_row(ROW_LOAD, 0, 255, 1'b0, 1'b0, ST_OK);
		add_row(ROW_LOAD, 0, 255, 1'b0, 1'b0, ST_OK);
		add_row(ROW_LOAD, 0, 255, 1'b0, 1'b0, ST_OK);
		add_row(ROW_QUERY, 0, 1, 1'b0, 1'b0, ST_OK);
		add_row(ROW_QUERY, 1, 1, 1'b0, 1'b0, ST_OK);
		add_row(ROW_QUERY, 1, 0, 1'b0, 1'b0, ST_OK);
		add_row(ROW_QUERY, 0, 0, 1'b0, 1'b0, ST_OK);
		add_row(ROW_QUERY, 2, 0, 1'b1, 1'b0, ST_RANGE);
		add_row(ROW_QUERY, 255, 255, 1'b1, 1'b0, ST_RANGE);
		// register write drops the frame; partial frame not ready
		add_row(ROW_CFG, int'(REG_LINE_COUNT), 1, 1'b0, 1'b0, ST_OK);
		add_row(ROW_QUERY, 0, 0, 1'b1, 1'b0, ST_NOT_READY);
		add_row(ROW_LOAD, 0, 1, 1'b0, 1'b0, ST_OK);
		add_row(ROW_QUERY, 0, 0, 1'b1, 1'b0, ST_NOT_READY);
		// wide spread selects the reduced rule
		add_row(ROW_LOAD, 0, 255, 1'b0, 1'b0, ST_OK);
		add_row(ROW_QUERY, 0, 0, 1'b0, 1'b0, ST_OK);
		add_row(ROW_QUERY, 0, 1, 1'b0, 1'b0, ST_OK);
		// write to an unassigned index leaves the frame alone
		add_row(ROW_CFG, int'(REG_UNUSED), 511, 1'b0, 1'b0, ST_OK);
		add_row(ROW_QUERY, 0, 1, 1'b0, 1'b0, ST_OK);
		// zero sizes clamp to one pixel, top floor leaves no bright pixels
		add_row(ROW_CFG, int'(REG_LINE_LENGTH), 0, 1'b0, 1'b0, ST_OK);
		add_row(ROW_CFG, int'(REG_LINE_COUNT), 0, 1'b0, 1'b0, ST_OK);
		add_row(ROW_CFG, int'(REG_STAT_FLOOR), 255, 1'b0, 1'b0, ST_OK);
		add_row(ROW_LOAD, 0, 200, 1'b0, 1'b0, ST_OK);
		add_row(ROW_QUERY, 0, 0, 1'b1, 1'b0, ST_OK);
		add_row(ROW_QUERY, 0, 1, 1'b1, 1'b0, ST_RANGE);
		// load after a complete frame starts over
		add_row(ROW_LOAD, 0, 0, 1'b0, 1'b0, ST_OK);
		add_row(ROW_QUERY, 0, 0, 1'b1, 1'b0, ST_OK);
		// flat frame, no spread
		add_row(ROW_CFG, int'(REG_LINE_LENGTH), 3, 1'b0, 1'b0, ST_OK);
		add_row(ROW_CFG, int'(REG_STAT_FLOOR), 100, 1'b0, 1'b0, ST_OK);
		add_row(ROW_LOAD, 0, 150, 1'b0, 1'b0, ST_OK);
		add_row(ROW_LOAD, 0, 150, 1'b0, 1'b0, ST_OK);
		add_row(ROW_LOAD, 0, 150, 1'b0, 1'b0, ST_OK);
		add_row(ROW_QUERY, 0, 1, 1'b0, 1'b0, ST_OK);
		add_row(ROW_QUERY, 0, 0, 1'b0, 1'b0, ST_OK);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[k]) begin
			row = plan[k];
			typed_res.fold = row.fold;
			typed_res.status = row.st;
			case (row.kind)
				ROW_CFG: begin
					settle_block();
					write_reg(row.a[CFG_IDX_W-1:0], row.b[DIM_W-1:0]);
				end
				ROW_LOAD: offer_item(CMD_LOAD, row.b[PIX_W-1:0], COORD_W'($urandom),
					COORD_W'($urandom), 1'b0, '0);
				default: offer_item(CMD_QUERY, PIX_W'($urandom), row.a[COORD_W-1:0],
					row.b[COORD_W-1:0], row.typed, typed_res);
			endcase
		end

		run_random_phases();

		s_tvalid <= 1'b0;
		while (fold_results_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

### sim.f
rtl/fmt_pkg.sv
rtl/fmt_ram.sv
rtl/fold_mask_threshold.sv
rtl/fmt_checker.sv
tb/testbench.sv
